>>> rtl/core/fpae_pkg.sv
// Shared types and constants of the frame auto-exposure controller.
package fpae_pkg;

	localparam int SUM_W  = 30;
	localparam int CNT_W  = 23;
	localparam int GAIN_W = 14;
	localparam int EXP_W  = 28;
	localparam int COEF_W = 16;
	localparam int CFG_W  = 28;
	localparam int IDX_W  = 4;
	localparam int ACC_W  = 51;

	localparam logic [IDX_W-1:0] REG_TARGET   = 4'd0;
	localparam logic [IDX_W-1:0] REG_KP       = 4'd1;
	localparam logic [IDX_W-1:0] REG_KI       = 4'd2;
	localparam logic [IDX_W-1:0] REG_KD       = 4'd3;
	localparam logic [IDX_W-1:0] REG_GAIN_LO  = 4'd4;
	localparam logic [IDX_W-1:0] REG_GAIN_HI  = 4'd5;
	localparam logic [IDX_W-1:0] REG_EXP_LO   = 4'd6;
	localparam logic [IDX_W-1:0] REG_EXP_HI   = 4'd7;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 14'd512;
	localparam logic [EXP_W-1:0]  EXP_RESET  = 28'd1280000;

	typedef struct packed {
		logic [7:0] pixel;
		logic       last_px;
	} px_in_t;

	typedef struct packed {
		logic [15:0]       mean_brightness;
		logic              over_exposed;
		logic [GAIN_W-1:0] new_gain;
		logic [EXP_W-1:0]  new_exposure;
		logic              exposure_adjusted;
	} ae_res_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] sat;
	} frm_t;

	typedef struct packed {
		logic [15:0]       target;
		logic [COEF_W-1:0] kp;
		logic [COEF_W-1:0] ki;
		logic [COEF_W-1:0] kd;
		logic [GAIN_W-1:0] gain_lo;
		logic [GAIN_W-1:0] gain_hi;
		logic [EXP_W-1:0]  exp_lo;
		logic [EXP_W-1:0]  exp_hi;
	} cfg_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_PREP  = 7'b0000100,
		ST_MUL_P = 7'b0001000,
		ST_MUL_I = 7'b0010000,
		ST_MUL_D = 7'b0100000,
		ST_APPLY = 7'b1000000
	} bk_state_t;

endpackage

>>> rtl/core/frame_pid_auto_exposure_top.sv
// Top level of the frame PID auto-exposure controller.
// Usage:
//  Pixels enter on in_item (pixel, last_px) with push; an item is taken when
//  push is high and full is low. Pixels stream at one per clock; full rises only
//  when two finished frames already wait for the back end.
//  One result per frame, on the pixel marked last_px, leaves on out_item while
//  empty is low and is taken when pop is high.
//  From the last_px pixel to the result on out_item, a frame passes the queue,
//  16 divider steps, 1 PID prep, 3 shared multiply steps and 1 update into the
//  output register, which waits while the receiver holds the last result. The
//  single shared divider and multiplier sequence serves one frame at a time.
//  If the receiver stalls, the result is held and the back end waits; frames
//  keep accumulating until the two-entry queue fills.
//  The user writes registers with cfg_we, cfg_idx, cfg_data only while idle;
//  the block does not enforce it. Reset clears accumulators, integral and last
//  error, sets gain to 512, exposure to 1280000, loads all register defaults.
module frame_pid_auto_exposure_top #(
	parameter int MAX_PIXELS       = 4194304,
	parameter int SATURATION_LEVEL = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  fpae_pkg::px_in_t   in_item,
	output logic               empty,
	input  logic               pop,
	output fpae_pkg::ae_res_t  out_item,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_idx,
	input  logic [27:0]        cfg_data
);
	import fpae_pkg::*;

	cfg_t cfg_q;
	frm_t wdata;
	frm_t rdata;
	logic wr;
	logic rd;
	logic q_full;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target  <= 16'd25600;
			cfg_q.kp      <= 16'd6554;
			cfg_q.ki      <= 16'd655;
			cfg_q.kd      <= 16'd3277;
			cfg_q.gain_lo <= 14'd0;
			cfg_q.gain_hi <= 14'd12288;
			cfg_q.exp_lo  <= 28'd1536;
			cfg_q.exp_hi  <= 28'd256000000;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TARGET:  cfg_q.target  <= cfg_data[15:0];
				REG_KP:      cfg_q.kp      <= cfg_data[15:0];
				REG_KI:      cfg_q.ki      <= cfg_data[15:0];
				REG_KD:      cfg_q.kd      <= cfg_data[15:0];
				REG_GAIN_LO: cfg_q.gain_lo <= cfg_data[GAIN_W-1:0];
				REG_GAIN_HI: cfg_q.gain_hi <= cfg_data[GAIN_W-1:0];
				REG_EXP_LO:  cfg_q.exp_lo  <= cfg_data[EXP_W-1:0];
				REG_EXP_HI:  cfg_q.exp_hi  <= cfg_data[EXP_W-1:0];
				default: ;
			endcase
		end
	end

	fpae_front #(
		.MAX_PIXELS       (MAX_PIXELS),
		.SATURATION_LEVEL (SATURATION_LEVEL)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_item (in_item),
		.q_full  (q_full),
		.full    (full),
		.q_push  (wr),
		.q_data  (wdata)
	);

	fpae_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.wdata  (wdata),
		.rd     (rd),
		.rdata  (rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	fpae_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_data   (rdata),
		.q_pop    (rd),
		.pop      (pop),
		.empty    (empty),
		.out_item (out_item)
	);

endmodule

>>> rtl/core/fpae_front.sv
// Pixel accumulator: sums, counts and saturation count of one frame.
module fpae_front #(
	parameter int MAX_PIXELS       = 4194304,
	parameter int SATURATION_LEVEL = 255
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fpae_pkg::px_in_t in_item,
	input  logic            q_full,
	output logic            full,
	output logic            q_push,
	output fpae_pkg::frm_t  q_data
);
	import fpae_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] sat_q;
	logic             take;
	logic             room;
	frm_t             nxt;

	assign full = q_full;
	assign take = push && !q_full;
	assign room = cnt_q < CNT_W'(MAX_PIXELS);

	always_comb begin
		nxt.sum   = sum_q;
		nxt.count = cnt_q;
		nxt.sat   = sat_q;
		if (room) begin
			nxt.sum   = sum_q + SUM_W'(in_item.pixel);
			nxt.count = cnt_q + CNT_W'(1);
			if (in_item.pixel == 8'(SATURATION_LEVEL))
				nxt.sat = sat_q + CNT_W'(1);
		end
	end

	assign q_push = take && in_item.last_px;
	assign q_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			sat_q <= '0;
		end else if (take) begin
			if (in_item.last_px) begin
				sum_q <= '0;
				cnt_q <= '0;
				sat_q <= '0;
			end else begin
				sum_q <= nxt.sum;
				cnt_q <= nxt.count;
				sat_q <= nxt.sat;
			end
		end
	end

endmodule

>>> rtl/core/fpae_fifo.sv
// Two-entry queue of finished frame totals between front and back.
module fpae_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  fpae_pkg::frm_t wdata,
	input  logic           rd,
	output fpae_pkg::frm_t rdata,
	output logic           full,
	output logic           empty
);
	import fpae_pkg::*;

	frm_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr && !full)
				wp_q <= !wp_q;
			if (rd && !empty)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
		end
	end

endmodule

>>> rtl/core/fpae_back.sv
// Per-frame mean divider, PID step, gain and exposure update and result register.
module fpae_back (
	input  logic            clk,
	input  logic            arst_n,
	input  fpae_pkg::cfg_t  cfg,
	input  logic            q_empty,
	input  fpae_pkg::frm_t  q_data,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output fpae_pkg::ae_res_t out_item
);
	import fpae_pkg::*;

	bk_state_t         state_q;
	logic [CNT_W-1:0]  rem_q;
	logic [15:0]       quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  sat_q;
	logic [3:0]        step_q;
	logic              over_q;
	logic              sig_q;
	logic signed [16:0] err_q;
	logic signed [32:0] integ_q;
	logic signed [18:0] deriv_q;
	logic signed [31:0] ierr_q;
	logic signed [17:0] last_q;
	logic [GAIN_W-1:0] gain_q;
	logic [EXP_W-1:0]  exp_q;
	logic signed [ACC_W-1:0] acc_q;
	logic              ovalid_q;
	ae_res_t           res_q;

	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic signed [16:0] err;
	logic signed [32:0] isum;
	logic signed [31:0] isat;
	logic [CNT_W+6:0]  sat100;
	logic signed [COEF_W:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] adj;
	logic signed [ACC_W:0] g;
	logic signed [ACC_W:0] e;
	logic signed [ACC_W:0] gc;
	logic signed [ACC_W:0] ec;
	logic              expb;
	logic              slot;

	assign empty    = !ovalid_q;
	assign out_item = res_q;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign slot     = !ovalid_q || pop;

	assign trial = {rem_q, quo_q[15]};
	assign diff  = trial - {1'b0, cnt_q};

	assign err    = $signed({1'b0, quo_q}) - $signed({1'b0, cfg.target});
	assign isum   = 33'(ierr_q) + 33'(err);
	assign isat   = (isum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
	                (isum < -33'sh0_8000_0000) ? 32'sh8000_0000 : isum[31:0];
	assign sat100 = {1'b0, sat_q, 6'b0} + {2'b0, sat_q, 5'b0} + {5'b0, sat_q, 2'b0};

	always_comb begin
		mul_a = $signed({1'b0, cfg.kp});
		mul_b = 33'(err_q);
		case (state_q)
			ST_MUL_I: begin
				mul_a = $signed({1'b0, cfg.ki});
				mul_b = integ_q;
			end
			ST_MUL_D: begin
				mul_a = $signed({1'b0, cfg.kd});
				mul_b = 33'(deriv_q);
			end
			default: begin
				mul_a = $signed({1'b0, cfg.kp});
				mul_b = 33'(err_q);
			end
		endcase
	end

	assign prod = ACC_W'(mul_a * mul_b);
	assign adj  = sig_q ? (acc_q >>> 15) : (acc_q >>> 17);
	assign expb = (gain_q > cfg.gain_hi) || (gain_q < cfg.gain_lo);
	assign g    = expb ? $signed({{(ACC_W-GAIN_W+1){1'b0}}, gain_q}) :
	              $signed({{(ACC_W-GAIN_W+1){1'b0}}, gain_q}) - (ACC_W+1)'(adj);
	assign e    = expb ? $signed({{(ACC_W-EXP_W+1){1'b0}}, exp_q}) - (ACC_W+1)'(adj) :
	              $signed({{(ACC_W-EXP_W+1){1'b0}}, exp_q});

	always_comb begin
		gc = g;
		if (gc < $signed({{(ACC_W-GAIN_W+1){1'b0}}, cfg.gain_lo}))
			gc = $signed({{(ACC_W-GAIN_W+1){1'b0}}, cfg.gain_lo});
		if (gc > $signed({{(ACC_W-GAIN_W+1){1'b0}}, cfg.gain_hi}))
			gc = $signed({{(ACC_W-GAIN_W+1){1'b0}}, cfg.gain_hi});
		ec = e;
		if (ec < $signed({{(ACC_W-EXP_W+1){1'b0}}, cfg.exp_lo}))
			ec = $signed({{(ACC_W-EXP_W+1){1'b0}}, cfg.exp_lo});
		if (ec > $signed({{(ACC_W-EXP_W+1){1'b0}}, cfg.exp_hi}))
			ec = $signed({{(ACC_W-EXP_W+1){1'b0}}, cfg.exp_hi});
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rem_q <= {1'b0, q_data.sum[SUM_W-1:8]};
				quo_q <= {q_data.sum[7:0], 8'b0};
				cnt_q <= q_data.count;
				sat_q <= q_data.sat;
			end
			ST_DIV: begin
				rem_q <= diff[CNT_W] ? trial[CNT_W-1:0] : diff[CNT_W-1:0];
				quo_q <= {quo_q[14:0], !diff[CNT_W]};
			end
			ST_PREP: begin
				over_q  <= sat100 > {7'b0, cnt_q};
				sig_q   <= (quo_q > cfg.target) || (sat100 > {7'b0, cnt_q});
				err_q   <= err;
				integ_q <= 33'(isat);
				deriv_q <= 19'(err) - 19'(last_q);
				acc_q   <= '0;
			end
			ST_MUL_P, ST_MUL_I, ST_MUL_D: acc_q <= acc_q + prod;
			default: ;
		endcase
		if (state_q == ST_APPLY && slot) begin
			res_q.mean_brightness   <= quo_q;
			res_q.over_exposed      <= over_q;
			res_q.new_gain          <= gc[GAIN_W-1:0];
			res_q.new_exposure      <= ec[EXP_W-1:0];
			res_q.exposure_adjusted <= expb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			ovalid_q <= 1'b0;
			ierr_q   <= '0;
			last_q   <= '0;
			gain_q   <= GAIN_RESET;
			exp_q    <= EXP_RESET;
		end else begin
			if (state_q == ST_APPLY && slot)
				ovalid_q <= 1'b1;
			else if (pop && ovalid_q)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (!q_empty)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					ierr_q  <= isat;
					last_q  <= 18'(err);
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: state_q <= ST_MUL_I;
				ST_MUL_I: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= ST_APPLY;
				ST_APPLY: begin
					if (slot) begin
						gain_q   <= gc[GAIN_W-1:0];
						exp_q    <= ec[EXP_W-1:0];
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("back state not one-hot");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < cnt_q))
		else $error("division remainder out of range");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !pop) |=> (ovalid_q && $stable(res_q)))
		else $error("waiting result lost");
	a_no_qpop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_DIV))
		else $error("frame taken without starting division");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the frame PID auto-exposure controller.
module testbench;
	import fpae_pkg::*;

	class ae_scoreboard;
		bit [15:0] target, kp, ki, kd;
		bit [13:0] gain_lo, gain_hi;
		bit [27:0] exp_lo, exp_hi;
		bit [31:0] frm_sum;
		bit [22:0] frm_count, frm_sat;
		longint integ_acc, prev_err;
		bit [13:0] gain;
		bit [27:0] exposure;
		ae_res_t pending_results[$];
		int errors;
		int frames;
		int exp_moves;

		function new();
			target = 16'd25600; kp = 16'd6554; ki = 16'd655; kd = 16'd3277;
			gain_lo = 0; gain_hi = 14'd12288; exp_lo = 28'd1536; exp_hi = 28'd256000000;
			frm_sum = 0; frm_count = 0; frm_sat = 0;
			integ_acc = 0; prev_err = 0;
			gain = GAIN_RESET; exposure = EXP_RESET;
			errors = 0; frames = 0; exp_moves = 0;
		endfunction

		function void write_reg(logic [3:0] idx, logic [27:0] data);
			case (idx)
				REG_TARGET:  target = data[15:0];
				REG_KP:      kp = data[15:0];
				REG_KI:      ki = data[15:0];
				REG_KD:      kd = data[15:0];
				REG_GAIN_LO: gain_lo = data[13:0];
				REG_GAIN_HI: gain_hi = data[13:0];
				REG_EXP_LO:  exp_lo = data;
				REG_EXP_HI:  exp_hi = data;
				default: ;
			endcase
		endfunction

		function longint clip(longint x, longint lo, longint hi);
			if (x < lo) x = lo;
			if (x > hi) x = hi;
			return x;
		endfunction

		function void note_pixel(px_in_t px);
			longint mean, err, deriv, acc, adj, g, e;
			bit over, moved;
			ae_res_t r;
			if (frm_count < 23'd4194304) begin
				frm_sum += px.pixel;
				frm_count++;
				if (px.pixel == 8'd255) frm_sat++;
			end
			if (!px.last_px) return;
			mean = (longint'(frm_sum) << 8) / longint'(frm_count);
			over = longint'(frm_sat) * 100 > longint'(frm_count);
			err = mean - longint'(target);
			integ_acc = clip(integ_acc + err, -64'sd2147483648, 64'sd2147483647);
			deriv = err - prev_err;
			prev_err = err;
			acc = longint'(kp) * err + longint'(ki) * integ_acc + longint'(kd) * deriv;
			adj = (mean > target || over) ? (acc >>> 15) : (acc >>> 17);
			moved = gain > gain_hi || gain < gain_lo;
			g = gain;
			e = exposure;
			if (moved) e = e - adj;
			else g = g - adj;
			gain = 14'(clip(g, gain_lo, gain_hi));
			exposure = 28'(clip(e, exp_lo, exp_hi));
			frm_sum = 0; frm_count = 0; frm_sat = 0;
			r.mean_brightness = mean[15:0];
			r.over_exposed = over;
			r.new_gain = gain;
			r.new_exposure = exposure;
			r.exposure_adjusted = moved;
			pending_results.push_back(r);
			frames++;
			if (moved) exp_moves++;
		endfunction

		function void check_result(ae_res_t got);
			ae_res_t want;
			if (pending_results.size() == 0) begin
				$error("result with none expected: %p", got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.mean_brightness !== want.mean_brightness) begin
				$error("mean_brightness expected %0d got %0d", want.mean_brightness,
					got.mean_brightness);
				errors++;
			end
			if (got.over_exposed !== want.over_exposed) begin
				$error("over_exposed expected %0d got %0d", want.over_exposed, got.over_exposed);
				errors++;
			end
			if (got.new_gain !== want.new_gain) begin
				$error("new_gain expected %0d got %0d", want.new_gain, got.new_gain);
				errors++;
			end
			if (got.new_exposure !== want.new_exposure) begin
				$error("new_exposure expected %0d got %0d", want.new_exposure, got.new_exposure);
				errors++;
			end
			if (got.exposure_adjusted !== want.exposure_adjusted) begin
				$error("exposure_adjusted expected %0d got %0d", want.exposure_adjusted,
					got.exposure_adjusted);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	px_in_t in_item = '0;
	logic empty;
	logic pop = 0;
	ae_res_t out_item;
	logic cfg_we = 0;
	logic [3:0] cfg_idx = '0;
	logic [27:0] cfg_data = '0;

	ae_scoreboard sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int stall_count = 0;
	int px_sent = 0;

	frame_pid_auto_exposure_top u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we),
		.cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.note_pixel(in_item);
			if (pop && !empty) sb.check_result(out_item);
			if ((push && !full) || (pop && !empty)) stall_count <= 0;
			else stall_count <= stall_count + 1;
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (stall_count > 5000) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic send_pixel(logic [7:0] p, logic fe);
		while ($urandom_range(99) < send_idle) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		in_item <= '{pixel: p, last_px: fe};
		@(posedge clk);
		while (full) @(posedge clk);
		px_sent++;
	endtask

	task automatic drain();
		push <= 0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_reg(logic [3:0] idx, logic [27:0] data);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// frame of random pixels; mode selects uniform content or biases it towards dark, bright or saturated
	task automatic send_frame(int len, int mode);
		logic [7:0] p;
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: p = 8'($urandom_range(255));
				1: p = 8'($urandom_range(20));
				2: p = 8'($urandom_range(255, 200));
				default: p = ($urandom_range(9) < 2) ? 8'd255 : 8'($urandom_range(255));
			endcase
			send_pixel(p, i == len - 1);
		end
	endtask

	task automatic random_regs(bit extreme);
		set_reg(REG_TARGET, extreme ? ($urandom_range(1) ? 28'hFFFF : 28'h0) :
			28'($urandom_range(65535)));
		set_reg(REG_KP, extreme ? 28'hFFFF : 28'($urandom_range(65535)));
		set_reg(REG_KI, extreme ? ($urandom_range(1) ? 28'hFFFF : 28'h0) :
			28'($urandom_range(4000)));
		set_reg(REG_KD, extreme ? 28'hFFFF : 28'($urandom_range(65535)));
		set_reg(REG_GAIN_LO, $urandom_range(1) ? 28'($urandom_range(16383)) :
			28'($urandom_range(600)));
		set_reg(REG_GAIN_HI, $urandom_range(1) ? 28'h3FFF : 28'($urandom_range(16383)));
		set_reg(REG_EXP_LO, $urandom_range(1) ? 28'h0 : 28'($urandom));
		set_reg(REG_EXP_HI, $urandom_range(1) ? 28'hFFFFFFF : 28'($urandom));
	endtask

	task automatic random_phase(int n_pixels);
		int done;
		done = 0;
		while (done < n_pixels) begin
			int len;
			len = ($urandom_range(9) == 0) ? $urandom_range(300, 120) : $urandom_range(12, 1);
			send_frame(len, $urandom_range(3));
			done += len;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: single-pixel frames at the extremes, saturation, overexposed frame
		send_pixel(8'd0, 1);
		send_pixel(8'd255, 1);
		send_pixel(8'd128, 0);
		send_pixel(8'd255, 1);
		send_pixel(8'd1, 0);
		send_pixel(8'd254, 0);
		send_pixel(8'd170, 0);
		send_pixel(8'd85, 1);
		for (int i = 0; i < 99; i++) send_pixel(8'd10, 0);
		send_pixel(8'd255, 1);
		send_pixel(8'd255, 0);
		for (int i = 0; i < 98; i++) send_pixel(8'd10, 0);
		send_pixel(8'd255, 1);
		drain();

		// gain outside limits, floor above ceiling, ignored register index
		set_reg(REG_GAIN_LO, 28'd3000);
		set_reg(REG_GAIN_HI, 28'd2000);
		set_reg(4'd9, 28'hFFFFFFF);
		set_reg(4'd15, 28'h0);
		send_pixel(8'd255, 1);
		send_pixel(8'd0, 1);
		drain();
		set_reg(REG_EXP_LO, 28'd5000000);
		set_reg(REG_EXP_HI, 28'd1000);
		send_pixel(8'd40, 1);
		drain();

		send_idle = 12; recv_idle = 60;
		random_regs(1);
		random_phase(250);
		drain();
		random_regs(0);
		random_phase(250);
		drain();
		send_idle = 60; recv_idle = 12;
		random_regs(0);
		random_phase(250);
		drain();
		random_regs(1);
		random_phase(250);
		drain();
		send_idle = 0; recv_idle = 0;
		random_regs(0);
		random_phase(270);
		drain();
		random_regs(0);
		random_phase(270);
		drain();

		$display("covered %0d pixels in %0d frames, %0d of them moving exposure,",
			px_sent, sb.frames, sb.exp_moves);
		$display("under sender and receiver stalls, extreme and random register sets");
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
